>>> rtl/tcce_pkg.sv
// Shared types, codes and helper functions of the TCP client connection engine.
package tcce_pkg;

  localparam logic [1:0] KIND_SEGMENT    = 2'd0;
  localparam logic [1:0] KIND_TRANSMIT   = 2'd1;
  localparam logic [1:0] KIND_TICK       = 2'd2;
  localparam logic [1:0] KIND_DISCONNECT = 2'd3;

  localparam logic [1:0] ACT_SEND      = 2'd0;
  localparam logic [1:0] ACT_RESEND    = 2'd1;
  localparam logic [1:0] ACT_GIVE_UP   = 2'd2;
  localparam logic [1:0] ACT_TOO_LONG  = 2'd3;

  localparam logic [1:0] CFG_REMOTE_PORT = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd2;

  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam logic [15:0] REMOTE_PORT_RESET = 16'd15118;
  localparam logic [9:0]  ACK_TIMEOUT_RESET = 10'd100;
  localparam logic [3:0]  MAX_RETRIES_RESET = 4'd10;
  localparam logic [31:0] LOCAL_SEQ_RESET   = 32'd200;
  localparam logic [15:0] LOCAL_PORT_FIRST  = 16'd60000;
  localparam logic [15:0] LOCAL_PORT_LAST   = 16'd65000;
  localparam logic [9:0]  ELAPSED_MAX       = 10'd1023;
  localparam logic [7:0]  LEVEL_CONNECT     = 8'd50;

  localparam logic [3:0] WORDS_PLAIN    = 4'd5;
  localparam logic [3:0] WORDS_SYN      = 4'd8;
  localparam logic [7:0] HDR_BYTES      = 8'd20;
  localparam logic [7:0] SYN_HDR_BYTES  = 8'd32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ip_payload_len;
    logic [3:0]  data_offset;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] peer_seq;
    logic [31:0] peer_ack;
    logic [7:0]  rx_flags;
    logic [7:0]  tx_payload_len;
    logic [7:0]  link_level;
  } item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [3:0]  header_words;
    logic [7:0]  segment_len;
    logic [7:0]  rx_len;
    logic [1:0]  conn_state;
    logic        last;
  } result_t;

  function automatic result_t send_result(logic [15:0] src, logic [15:0] dst,
                                          logic [31:0] seq, logic [31:0] ack,
                                          logic [7:0] flags, logic [3:0] words,
                                          logic [7:0] seglen, logic [7:0] rxlen);
    result_t r;
    r.action       = ACT_SEND;
    r.src_port     = src;
    r.dst_port     = dst;
    r.seq          = seq;
    r.ack          = ack;
    r.flags        = flags;
    r.header_words = words;
    r.segment_len  = seglen;
    r.rx_len       = rxlen;
    r.conn_state   = 2'd0;
    r.last         = 1'b0;
    return r;
  endfunction

  // Non-send results carry the action code with all header fields zero.
  function automatic result_t event_result(logic [1:0] action);
    result_t r;
    r        = '0;
    r.action = action;
    return r;
  endfunction

endpackage

>>> rtl/tcp_client_connection_engine_top.sv
// TCP client connection engine: connection state machine, timeout and segment header fields.
//
//   channel | handshake          | contents
//   --------+--------------------+------------------------------------------------
//   in      | in_valid/in_stall  | one event: segment, transmit, tick, disconnect
//   out     | out_valid/out_stall| one result: send, resend, give up, too long
//   cfg     | cfg_valid/cfg_ready| register index and write data, always ready
//
// An event is registered on input, then evaluated combinationally into a two-entry
// result queue once the queue empties; a new event can be accepted every cycle when
// it gives at most one result and the output does not stall, and an event with two
// results holds off the next event until both of its results are taken.
// Reset is synchronous; it resets the connection state and registers and empties the queue.
// A stalled output holds the queue, which in turn stalls the input register.
module tcp_client_connection_engine_top #(
  parameter int RX_DATA_LIMIT    = 128,
  parameter int TX_SEGMENT_LIMIT = 200
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] ip_payload_len,
  input  logic [3:0]  data_offset,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [31:0] peer_seq,
  input  logic [31:0] peer_ack,
  input  logic [7:0]  rx_flags,
  input  logic [7:0]  tx_payload_len,
  input  logic [7:0]  link_level,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [7:0]  out_flags,
  output logic [3:0]  out_header_words,
  output logic [7:0]  out_segment_len,
  output logic [7:0]  rx_data_len,
  output logic [1:0]  conn_state,
  output logic        last
);

  typedef enum logic [1:0] {
    ST_CLOSED      = 2'd0,
    ST_SYN_SENT    = 2'd1,
    ST_ESTABLISHED = 2'd2
  } link_state_t;

  // Configuration registers.
  logic [15:0] remote_port;
  logic [9:0]  ack_timeout_ms;
  logic [3:0]  max_retries;

  // Connection state.
  link_state_t link_state, link_state_next;
  logic [31:0] local_seq, local_seq_next;
  logic [31:0] ack_to_send, ack_to_send_next;
  logic [15:0] local_port, local_port_next;
  logic        wait_armed, wait_armed_next;
  logic [9:0]  wait_elapsed, wait_elapsed_next;
  logic [3:0]  retries_left, retries_left_next;

  // Input register and result queue.
  tcce_pkg::item_t   item;
  logic              item_valid;
  tcce_pkg::result_t queue [2];
  tcce_pkg::result_t queue_next [2];
  logic [1:0]        cnt, cnt_next;
  logic              pop;
  logic [1:0]        cnt_pop;
  logic              exec;

  // Step results.
  tcce_pkg::result_t res [2];
  logic [1:0]        res_n;

  // Step datapath.
  logic [5:0]  hdr_len;
  logic [15:0] pay;
  logic        port_ok;
  logic [8:0]  tx_total;
  logic [9:0]  elapsed_inc;
  logic [15:0] port_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_port    <= tcce_pkg::REMOTE_PORT_RESET;
      ack_timeout_ms <= tcce_pkg::ACK_TIMEOUT_RESET;
      max_retries    <= tcce_pkg::MAX_RETRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcce_pkg::CFG_REMOTE_PORT: remote_port    <= cfg_data;
        tcce_pkg::CFG_ACK_TIMEOUT: ack_timeout_ms <= cfg_data[9:0];
        tcce_pkg::CFG_MAX_RETRIES: max_retries    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign pop      = (cnt != 2'd0) && !out_stall;
  assign cnt_pop  = cnt - {1'b0, pop};
  assign exec     = item_valid && (cnt_pop == 2'd0);
  assign in_stall = item_valid && !exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      item.kind           <= kind;
      item.ip_payload_len <= ip_payload_len;
      item.data_offset    <= data_offset;
      item.source_port    <= source_port;
      item.dest_port      <= dest_port;
      item.peer_seq       <= peer_seq;
      item.peer_ack       <= peer_ack;
      item.rx_flags       <= rx_flags;
      item.tx_payload_len <= tx_payload_len;
      item.link_level     <= link_level;
    end
  end

  assign hdr_len     = {item.data_offset, 2'b00};
  assign pay         = (item.ip_payload_len >= {10'd0, hdr_len}) ?
                       item.ip_payload_len - {10'd0, hdr_len} : 16'd0;
  assign port_ok     = (item.source_port == remote_port) && (item.dest_port == local_port);
  assign tx_total    = {1'b0, item.tx_payload_len} + {1'b0, tcce_pkg::HDR_BYTES};
  assign elapsed_inc = (wait_elapsed < tcce_pkg::ELAPSED_MAX) ? wait_elapsed + 10'd1
                                                              : wait_elapsed;
  assign port_inc    = local_port + 16'd1;

  // One event step. Send results take the state values current at the moment
  // they are produced; the connection state field is patched in at the end.
  always_comb begin
    link_state_next   = link_state;
    local_seq_next    = local_seq;
    ack_to_send_next  = ack_to_send;
    local_port_next   = local_port;
    wait_armed_next   = wait_armed;
    wait_elapsed_next = wait_elapsed;
    retries_left_next = retries_left;
    res[0]            = '0;
    res[1]            = '0;
    res_n             = 2'd0;

    case (item.kind)
      tcce_pkg::KIND_SEGMENT: begin
        if (port_ok) begin
          if (item.rx_flags == (tcce_pkg::FLAG_SYN | tcce_pkg::FLAG_ACK)) begin
            if (link_state == ST_SYN_SENT) begin
              local_seq_next   = item.peer_ack;
              ack_to_send_next = item.peer_seq + 32'd1;
              link_state_next  = ST_ESTABLISHED;
              res[0] = tcce_pkg::send_result(local_port, remote_port, item.peer_ack,
                                             item.peer_seq + 32'd1, tcce_pkg::FLAG_ACK,
                                             tcce_pkg::WORDS_PLAIN, tcce_pkg::HDR_BYTES,
                                             8'd0);
              res_n  = 2'd1;
            end
          end else if (link_state == ST_ESTABLISHED) begin
            if (pay != 16'd0 && pay < 16'(RX_DATA_LIMIT)) begin
              ack_to_send_next = item.peer_seq + {16'd0, pay};
              res[0] = tcce_pkg::send_result(local_port, remote_port, local_seq,
                                             item.peer_seq + {16'd0, pay},
                                             tcce_pkg::FLAG_ACK, tcce_pkg::WORDS_PLAIN,
                                             tcce_pkg::HDR_BYTES, pay[7:0]);
              res_n  = 2'd1;
            end
            if ((item.rx_flags & tcce_pkg::FLAG_ACK) != 8'd0) begin
              local_seq_next    = item.peer_ack;
              wait_armed_next   = 1'b0;
              retries_left_next = 4'd0;
            end
          end
        end
      end
      tcce_pkg::KIND_TRANSMIT: begin
        if (link_state == ST_ESTABLISHED) begin
          res_n = 2'd1;
          if (tx_total < 9'(TX_SEGMENT_LIMIT)) begin
            res[0] = tcce_pkg::send_result(local_port, remote_port, local_seq, ack_to_send,
                                           tcce_pkg::FLAG_PSH | tcce_pkg::FLAG_ACK,
                                           tcce_pkg::WORDS_PLAIN, tx_total[7:0], 8'd0);
            wait_armed_next   = 1'b1;
            wait_elapsed_next = 10'd0;
            retries_left_next = max_retries;
          end else begin
            res[0] = tcce_pkg::event_result(tcce_pkg::ACT_TOO_LONG);
          end
        end
      end
      tcce_pkg::KIND_TICK: begin
        if (wait_armed) begin
          wait_elapsed_next = elapsed_inc;
          if (elapsed_inc > ack_timeout_ms) begin
            res_n = 2'd1;
            if (retries_left != 4'd0) begin
              res[0]            = tcce_pkg::event_result(tcce_pkg::ACT_RESEND);
              wait_elapsed_next = 10'd0;
              retries_left_next = retries_left - 4'd1;
            end else begin
              res[0]          = tcce_pkg::event_result(tcce_pkg::ACT_GIVE_UP);
              wait_armed_next = 1'b0;
            end
          end
        end
        if (item.link_level < tcce_pkg::LEVEL_CONNECT) begin
          wait_armed_next = 1'b0;
          link_state_next = ST_CLOSED;
        end else if (item.link_level == tcce_pkg::LEVEL_CONNECT &&
                     link_state == ST_CLOSED) begin
          local_port_next = (port_inc > tcce_pkg::LOCAL_PORT_LAST) ?
                            tcce_pkg::LOCAL_PORT_FIRST : port_inc;
          link_state_next = ST_SYN_SENT;
          res[res_n[0]] = tcce_pkg::send_result(local_port_next, remote_port, local_seq,
                                                ack_to_send, tcce_pkg::FLAG_SYN,
                                                tcce_pkg::WORDS_SYN,
                                                tcce_pkg::SYN_HDR_BYTES, 8'd0);
          res_n = res_n + 2'd1;
        end
      end
      default: begin
        link_state_next = ST_CLOSED;
      end
    endcase

    res[0].conn_state = link_state_next;
    res[1].conn_state = link_state_next;
    res[0].last       = (res_n == 2'd1);
    res[1].last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_state   <= ST_CLOSED;
      local_seq    <= tcce_pkg::LOCAL_SEQ_RESET;
      ack_to_send  <= 32'd0;
      local_port   <= tcce_pkg::LOCAL_PORT_FIRST;
      wait_armed   <= 1'b0;
      wait_elapsed <= 10'd0;
      retries_left <= 4'd0;
    end else if (exec) begin
      link_state   <= link_state_next;
      local_seq    <= local_seq_next;
      ack_to_send  <= ack_to_send_next;
      local_port   <= local_port_next;
      wait_armed   <= wait_armed_next;
      wait_elapsed <= wait_elapsed_next;
      retries_left <= retries_left_next;
    end
  end

  // The queue is always empty after the pop when an event is evaluated, so the
  // new results land at the head.
  always_comb begin
    queue_next[0] = queue[0];
    queue_next[1] = queue[1];
    cnt_next      = cnt_pop;
    if (pop) begin
      queue_next[0] = queue[1];
    end
    if (exec && res_n != 2'd0) begin
      queue_next[0] = res[0];
      queue_next[1] = res[1];
      cnt_next      = res_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    queue[0] <= queue_next[0];
    queue[1] <= queue_next[1];
  end

  assign out_valid        = (cnt != 2'd0);
  assign action           = queue[0].action;
  assign out_source_port  = queue[0].src_port;
  assign out_dest_port    = queue[0].dst_port;
  assign out_seq          = queue[0].seq;
  assign out_ack          = queue[0].ack;
  assign out_flags        = queue[0].flags;
  assign out_header_words = queue[0].header_words;
  assign out_segment_len  = queue[0].segment_len;
  assign rx_data_len      = queue[0].rx_len;
  assign conn_state       = queue[0].conn_state;
  assign last             = queue[0].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue count out of range");

  a_pair_head: assert property (@(posedge clk) disable iff (rst)
                                out_valid && !last |-> cnt == 2'd2)
    else $error("first result of a pair without its partner in the queue");

  a_event_zero: assert property (@(posedge clk) disable iff (rst)
                                 out_valid && action != tcce_pkg::ACT_SEND |->
                                 out_seq == 32'd0 && out_flags == 8'd0 &&
                                 out_source_port == 16'd0)
    else $error("non-send result carries header fields");

  a_disconnect: assert property (@(posedge clk) disable iff (rst)
                                 exec && item.kind == tcce_pkg::KIND_DISCONNECT |=>
                                 link_state == ST_CLOSED)
    else $error("disconnect did not close the connection");

  a_port_range: assert property (@(posedge clk) disable iff (rst)
                                 local_port >= tcce_pkg::LOCAL_PORT_FIRST &&
                                 local_port <= tcce_pkg::LOCAL_PORT_LAST)
    else $error("local port left its range");

endmodule

>>> test/tb_tcp_client_connection_engine_top.sv
// Testbench for the TCP client connection engine: a directed table and predictor-checked random traffic.
`timescale 1ns / 1ps

module tb_tcp_client_connection_engine_top;
  import tcce_pkg::*;

  localparam int RX_DATA_LIMIT    = 128;
  localparam int TX_SEGMENT_LIMIT = 200;

  localparam logic [1:0] ST_CLOSED      = 2'd0;
  localparam logic [1:0] ST_SYN_SENT    = 2'd1;
  localparam logic [1:0] ST_ESTABLISHED = 2'd2;

  localparam int NOT_TYPED       = -1;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 157;
  localparam int SHOWN_MAX       = 10;

  localparam logic [15:0] PORT_1 = LOCAL_PORT_FIRST + 16'd1;
  localparam logic [15:0] PORT_2 = LOCAL_PORT_FIRST + 16'd2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = '0;
  logic [15:0] ip_payload_len = '0;
  logic [3:0]  data_offset = '0;
  logic [15:0] source_port = '0;
  logic [15:0] dest_port = '0;
  logic [31:0] peer_seq = '0;
  logic [31:0] peer_ack = '0;
  logic [7:0]  rx_flags = '0;
  logic [7:0]  tx_payload_len = '0;
  logic [7:0]  link_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  action;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [7:0]  out_flags;
  logic [3:0]  out_header_words;
  logic [7:0]  out_segment_len;
  logic [7:0]  rx_data_len;
  logic [1:0]  conn_state;
  logic        last;

  // Predicted connection state and register copies.
  logic [15:0] server_port = REMOTE_PORT_RESET;
  logic [9:0]  timeout_ms  = ACK_TIMEOUT_RESET;
  logic [3:0]  retry_limit = MAX_RETRIES_RESET;
  logic [1:0]  conn_st     = ST_CLOSED;
  logic [31:0] next_seq    = LOCAL_SEQ_RESET;
  logic [31:0] ack_due     = '0;
  logic [15:0] my_port     = LOCAL_PORT_FIRST;
  logic        timer_on    = 1'b0;
  logic [9:0]  timer_ms    = '0;
  logic [3:0]  tries_left  = '0;

  result_t expected_results[$];
  int      error_count = 0;
  int      shown_mismatches = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_asks = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    item_t       ev;
    int          typed_n;
    result_t     typed;
  } plan_row_t;

  tcp_client_connection_engine_top #(
    .RX_DATA_LIMIT(RX_DATA_LIMIT),
    .TX_SEGMENT_LIMIT(TX_SEGMENT_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .ip_payload_len(ip_payload_len),
    .data_offset(data_offset),
    .source_port(source_port),
    .dest_port(dest_port),
    .peer_seq(peer_seq),
    .peer_ack(peer_ack),
    .rx_flags(rx_flags),
    .tx_payload_len(tx_payload_len),
    .link_level(link_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .action(action),
    .out_source_port(out_source_port),
    .out_dest_port(out_dest_port),
    .out_seq(out_seq),
    .out_ack(out_ack),
    .out_flags(out_flags),
    .out_header_words(out_header_words),
    .out_segment_len(out_segment_len),
    .rx_data_len(rx_data_len),
    .conn_state(conn_state),
    .last(last)
  );

  always #5 clk = ~clk;

  function automatic result_t make_result(logic [1:0] act, logic [15:0] sp, logic [15:0] dp,
                                          logic [31:0] sq, logic [31:0] ak, logic [7:0] fl,
                                          logic [3:0] wd, logic [7:0] sl, logic [7:0] rl,
                                          logic [1:0] st, logic lst);
    result_t r;
    r.action       = act;
    r.src_port     = sp;
    r.dst_port     = dp;
    r.seq          = sq;
    r.ack          = ak;
    r.flags        = fl;
    r.header_words = wd;
    r.segment_len  = sl;
    r.rx_len       = rl;
    r.conn_state   = st;
    r.last         = lst;
    return r;
  endfunction

  function automatic result_t quiet_result(logic [1:0] act, logic [1:0] st, logic lst);
    return make_result(act, '0, '0, '0, '0, '0, '0, '0, '0, st, lst);
  endfunction

  // Header fields of a segment sent from the current connection state.
  function automatic result_t sent_segment(logic [7:0] fl, logic [3:0] wd, logic [7:0] sl,
                                           logic [7:0] rl);
    return make_result(ACT_SEND, my_port, server_port, next_seq, ack_due, fl, wd, sl, rl,
                       2'd0, 1'b0);
  endfunction

  function automatic int predict_connection_event(input item_t ev, output result_t r0,
                                                  output result_t r1);
    result_t     rs [2];
    int          n;
    int          k;
    int unsigned plen;
    int unsigned hlen;
    int unsigned pay;
    n     = 0;
    rs[0] = '0;
    rs[1] = '0;
    case (ev.kind)
      KIND_SEGMENT: begin
        plen = ev.ip_payload_len;
        hlen = ev.data_offset;
        hlen = hlen * 4;
        pay  = (plen >= hlen) ? plen - hlen : 0;
        if (ev.source_port == server_port && ev.dest_port == my_port) begin
          if (ev.rx_flags == (FLAG_SYN | FLAG_ACK)) begin
            if (conn_st == ST_SYN_SENT) begin
              next_seq = ev.peer_ack;
              ack_due  = ev.peer_seq + 32'd1;
              conn_st  = ST_ESTABLISHED;
              rs[n]    = sent_segment(FLAG_ACK, WORDS_PLAIN, HDR_BYTES, 8'd0);
              n++;
            end
          end else if (conn_st == ST_ESTABLISHED) begin
            if (pay > 0 && pay < RX_DATA_LIMIT) begin
              ack_due = ev.peer_seq + pay;
              rs[n]   = sent_segment(FLAG_ACK, WORDS_PLAIN, HDR_BYTES, pay[7:0]);
              n++;
            end
            // The ACK flag still counts when the data itself was refused.
            if ((ev.rx_flags & FLAG_ACK) != 8'd0) begin
              next_seq   = ev.peer_ack;
              timer_on   = 1'b0;
              tries_left = '0;
            end
          end
        end
      end
      KIND_TRANSMIT: begin
        if (conn_st == ST_ESTABLISHED) begin
          if (int'(ev.tx_payload_len) + int'(HDR_BYTES) < TX_SEGMENT_LIMIT) begin
            rs[0]      = sent_segment(FLAG_PSH | FLAG_ACK, WORDS_PLAIN,
                                      HDR_BYTES + ev.tx_payload_len, 8'd0);
            timer_on   = 1'b1;
            timer_ms   = '0;
            tries_left = retry_limit;
          end else begin
            rs[0] = quiet_result(ACT_TOO_LONG, 2'd0, 1'b0);
          end
          n = 1;
        end
      end
      KIND_TICK: begin
        // The acknowledge timeout is handled before the link level.
        if (timer_on) begin
          if (timer_ms < ELAPSED_MAX) timer_ms = timer_ms + 10'd1;
          if (timer_ms > timeout_ms) begin
            if (tries_left > 0) begin
              rs[n]      = quiet_result(ACT_RESEND, 2'd0, 1'b0);
              timer_ms   = '0;
              tries_left = tries_left - 4'd1;
            end else begin
              rs[n]    = quiet_result(ACT_GIVE_UP, 2'd0, 1'b0);
              timer_on = 1'b0;
            end
            n++;
          end
        end
        if (ev.link_level < LEVEL_CONNECT) begin
          timer_on = 1'b0;
          conn_st  = ST_CLOSED;
        end else if (ev.link_level == LEVEL_CONNECT && conn_st == ST_CLOSED) begin
          my_port = my_port + 16'd1;
          if (my_port > LOCAL_PORT_LAST) my_port = LOCAL_PORT_FIRST;
          rs[n]   = sent_segment(FLAG_SYN, WORDS_SYN, SYN_HDR_BYTES, 8'd0);
          n++;
          conn_st = ST_SYN_SENT;
        end
      end
      default: begin
        conn_st = ST_CLOSED;
      end
    endcase
    for (k = 0; k < n; k++) begin
      rs[k].conn_state = conn_st;
      rs[k].last       = (k == n - 1);
    end
    r0 = rs[0];
    r1 = rs[1];
    return n;
  endfunction

  function automatic item_t mk_seg(logic [15:0] plen, logic [3:0] off, logic [15:0] sp,
                                   logic [15:0] dp, logic [31:0] sq, logic [31:0] ak,
                                   logic [7:0] fl);
    item_t ev;
    ev                = '0;
    ev.kind           = KIND_SEGMENT;
    ev.ip_payload_len = plen;
    ev.data_offset    = off;
    ev.source_port    = sp;
    ev.dest_port      = dp;
    ev.peer_seq       = sq;
    ev.peer_ack       = ak;
    ev.rx_flags       = fl;
    return ev;
  endfunction

  function automatic item_t mk_tx(logic [7:0] len);
    item_t ev;
    ev                = '0;
    ev.kind           = KIND_TRANSMIT;
    ev.tx_payload_len = len;
    return ev;
  endfunction

  function automatic item_t mk_tick(logic [7:0] level);
    item_t ev;
    ev            = '0;
    ev.kind       = KIND_TICK;
    ev.link_level = level;
    return ev;
  endfunction

  function automatic plan_row_t ev_row(item_t ev, int typed_n, result_t typed);
    plan_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.ev      = ev;
    row.typed_n = typed_n;
    row.typed   = typed;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [15:0] val);
    plan_row_t row;
    row         = ev_row('0, 0, '0);
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Random event shaped by the predicted state: mostly sequences that move the
  // connection forward, with junk in the fields that the kind does not use.
  function automatic item_t gen_event(output bit noise);
    item_t ev;
    int    pick;
    ev.kind           = 2'($urandom);
    ev.ip_payload_len = 16'($urandom);
    ev.data_offset    = 4'($urandom);
    ev.source_port    = 16'($urandom);
    ev.dest_port      = 16'($urandom);
    ev.peer_seq       = $urandom;
    ev.peer_ack       = $urandom;
    ev.rx_flags       = 8'($urandom);
    ev.tx_payload_len = 8'($urandom);
    ev.link_level     = 8'($urandom);
    noise = 1'b0;
    pick  = $urandom_range(99);
    if (pick < 12) begin
      noise = 1'b1;
    end else begin
      case (conn_st)
        ST_CLOSED: begin
          if (pick < 75) begin
            ev.kind       = KIND_TICK;
            ev.link_level = LEVEL_CONNECT;
          end else if (pick < 90) begin
            ev.kind = KIND_TICK;
          end else begin
            ev.kind        = KIND_SEGMENT;
            ev.source_port = server_port;
            ev.dest_port   = my_port;
          end
        end
        ST_SYN_SENT: begin
          if (pick < 75) begin
            ev.kind        = KIND_SEGMENT;
            ev.source_port = server_port;
            ev.dest_port   = my_port;
            ev.rx_flags    = FLAG_SYN | FLAG_ACK;
          end else if (pick < 88) begin
            ev.kind       = KIND_TICK;
            ev.link_level = 8'($urandom_range(50, 255));
          end else if (pick < 94) begin
            ev.kind       = KIND_TICK;
            ev.link_level = 8'($urandom_range(0, 49));
          end else begin
            ev.kind = KIND_DISCONNECT;
          end
        end
        default: begin
          if (pick < 42) begin
            ev.kind           = KIND_SEGMENT;
            ev.source_port    = server_port;
            ev.dest_port      = my_port;
            ev.data_offset    = ($urandom_range(7) == 0) ? 4'($urandom) : WORDS_PLAIN;
            ev.ip_payload_len = 16'({ev.data_offset, 2'b00}) +
                                16'($urandom_range(0, 140));
            if ($urandom_range(3) != 0)
              ev.rx_flags = FLAG_ACK | (($urandom_range(1) == 1) ? FLAG_PSH : 8'h00);
          end else if (pick < 64) begin
            ev.kind = KIND_TRANSMIT;
            if ($urandom_range(4) != 0) ev.tx_payload_len = 8'($urandom_range(0, 179));
          end else if (pick < 94) begin
            ev.kind       = KIND_TICK;
            ev.link_level = ($urandom_range(19) == 0) ? 8'($urandom_range(0, 49))
                                                      : 8'($urandom_range(50, 255));
          end else if (pick < 97) begin
            ev.kind = KIND_DISCONNECT;
          end else begin
            ev.kind        = KIND_SEGMENT;
            ev.source_port = server_port;
            ev.dest_port   = my_port;
            ev.rx_flags    = FLAG_SYN | FLAG_ACK;
          end
        end
      endcase
    end
    return ev;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (shown_mismatches < SHOWN_MAX)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      shown_mismatches++;
    end
  endfunction

  task automatic offer_event(input item_t ev, input int typed_n, input result_t typed);
    result_t r0;
    result_t r1;
    int      n;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind           <= ev.kind;
    ip_payload_len <= ev.ip_payload_len;
    data_offset    <= ev.data_offset;
    source_port    <= ev.source_port;
    dest_port      <= ev.dest_port;
    peer_seq       <= ev.peer_seq;
    peer_ack       <= ev.peer_ack;
    rx_flags       <= ev.rx_flags;
    tx_payload_len <= ev.tx_payload_len;
    link_level     <= ev.link_level;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    n = predict_connection_event(ev, r0, r1);
    if (typed_n == NOT_TYPED) begin
      if (n > 0) expected_results.push_back(r0);
      if (n > 1) expected_results.push_back(r1);
    end else if (typed_n > 0) begin
      expected_results.push_back(typed);
    end
  endtask

  // Events that give no result may still be in flight, hence the extra cycles.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REMOTE_PORT: server_port = val;
      CFG_ACK_TIMEOUT: timeout_ms  = val[9:0];
      CFG_MAX_RETRIES: retry_limit = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = make_result(action, out_source_port, out_dest_port, out_seq, out_ack, out_flags,
                        out_header_words, out_segment_len, rx_data_len, conn_state, last);
      if (expected_results.size() == 0) begin
        error_count++;
        if (shown_mismatches < SHOWN_MAX)
          $display("%0t: result with nothing expected: %p", $realtime, got);
        shown_mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("action", want.action, got.action);
        check_field("out_source_port", want.src_port, got.src_port);
        check_field("out_dest_port", want.dst_port, got.dst_port);
        check_field("out_seq", want.seq, got.seq);
        check_field("out_ack", want.ack, got.ack);
        check_field("out_flags", want.flags, got.flags);
        check_field("out_header_words", want.header_words, got.header_words);
        check_field("out_segment_len", want.segment_len, got.segment_len);
        check_field("rx_data_len", want.rx_len, got.rx_len);
        check_field("conn_state", want.conn_state, got.conn_state);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tcp_client_connection_engine_top test failed");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan[$];
    item_t       ev;
    bit          noise;
    int          done;
    logic [15:0] rp;
    logic [15:0] to;
    logic [15:0] mr;

    // Connect from reset, then port checks and the stray SYN+ACK.
    plan.push_back(ev_row(mk_tick(LEVEL_CONNECT), 1,
                          make_result(ACT_SEND, PORT_1, REMOTE_PORT_RESET, LOCAL_SEQ_RESET,
                                      32'd0, FLAG_SYN, WORDS_SYN, SYN_HDR_BYTES, 8'd0,
                                      ST_SYN_SENT, 1'b1)));
    plan.push_back(ev_row(mk_seg(16'd20, 4'd5, REMOTE_PORT_RESET + 16'd1, PORT_1, 32'd5,
                                 32'd6, FLAG_SYN | FLAG_ACK), 0, '0));
    plan.push_back(ev_row(mk_seg(16'd20, 4'd5, REMOTE_PORT_RESET, LOCAL_PORT_FIRST, 32'd5,
                                 32'd6, FLAG_SYN | FLAG_ACK), 0, '0));
    plan.push_back(ev_row(mk_seg(16'd20, 4'd5, REMOTE_PORT_RESET, PORT_1, 32'hFFFF_FFFF,
                                 32'h0000_1000, FLAG_SYN | FLAG_ACK), 1,
                          make_result(ACT_SEND, PORT_1, REMOTE_PORT_RESET, 32'h0000_1000,
                                      32'd0, FLAG_ACK, WORDS_PLAIN, HDR_BYTES, 8'd0,
                                      ST_ESTABLISHED, 1'b1)));
    plan.push_back(ev_row(mk_seg(16'd20, 4'd5, REMOTE_PORT_RESET, PORT_1, 32'd9, 32'd9,
                                 FLAG_SYN | FLAG_ACK), 0, '0));
    // Received data: largest accepted, oversized, empty and single byte.
    plan.push_back(ev_row(mk_seg(16'd147, 4'd5, REMOTE_PORT_RESET, PORT_1, 32'h8000_0000,
                                 32'h0000_2000, FLAG_ACK), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_seg(16'd148, 4'd5, REMOTE_PORT_RESET, PORT_1, 32'h1234_5678,
                                 32'hFFFF_FFFF, FLAG_PSH | FLAG_ACK), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_seg(16'd0, 4'd15, REMOTE_PORT_RESET, PORT_1, 32'd0, 32'd0,
                                 8'h00), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_seg(16'hFFFF, 4'd0, REMOTE_PORT_RESET, PORT_1, 32'd77,
                                 32'h0000_3000, 8'hFF), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_seg(16'd21, 4'd5, REMOTE_PORT_RESET, PORT_1, 32'd0, 32'd0,
                                 8'h00), NOT_TYPED, '0));
    // Transmit lengths around the segment limit.
    plan.push_back(ev_row(mk_tx(8'd179), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_tx(8'd180), 1, quiet_result(ACT_TOO_LONG, ST_ESTABLISHED, 1'b1)));
    plan.push_back(ev_row(mk_tx(8'd255), 1, quiet_result(ACT_TOO_LONG, ST_ESTABLISHED, 1'b1)));
    plan.push_back(ev_row(mk_tx(8'd0), NOT_TYPED, '0));
    // Disconnect leaves the timeout armed; closed ignores transmits and segments.
    plan.push_back(ev_row(mk_seg(16'd0, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0, 8'h00)
                          ^ {KIND_DISCONNECT ^ KIND_SEGMENT, 140'd0}, 0, '0));
    plan.push_back(ev_row(mk_tx(8'd10), 0, '0));
    plan.push_back(ev_row(mk_seg(16'd30, 4'd5, REMOTE_PORT_RESET, PORT_1, 32'd1, 32'd2,
                                 FLAG_ACK), 0, '0));
    plan.push_back(ev_row(mk_tick(8'd255), NOT_TYPED, '0));
    // One tick gives a resend followed by a SYN.
    plan.push_back(reg_row(CFG_ACK_TIMEOUT, 16'd1));
    plan.push_back(ev_row(mk_tick(LEVEL_CONNECT), NOT_TYPED, '0));
    // With no retries the first timeout gives up.
    plan.push_back(reg_row(CFG_MAX_RETRIES, 16'd0));
    plan.push_back(ev_row(mk_seg(16'd20, 4'd5, REMOTE_PORT_RESET, PORT_2, 32'd100, 32'd500,
                                 FLAG_SYN | FLAG_ACK), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_tx(8'd10), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_tick(LEVEL_CONNECT + 8'd1), NOT_TYPED, '0));
    plan.push_back(ev_row(mk_tick(LEVEL_CONNECT + 8'd1), 1,
                          quiet_result(ACT_GIVE_UP, ST_ESTABLISHED, 1'b1)));
    plan.push_back(ev_row(mk_tick(8'd0), NOT_TYPED, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_event(plan[i].ev, plan[i].typed_n, plan[i].typed);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          rp = REMOTE_PORT_RESET;
          to = 16'd1;
          mr = 16'd0;
        end
        1: begin
          rp = 16'h0000;
          to = 16'd1000;
          mr = 16'd15;
        end
        2: begin
          rp = 16'hFFFF;
          to = 16'd2;
          mr = 16'd1;
        end
        default: begin
          rp = ($urandom_range(3) == 0) ? 16'($urandom) : REMOTE_PORT_RESET;
          to = 16'($urandom_range(1, 6));
          mr = 16'($urandom_range(0, 15));
        end
      endcase
      write_reg(CFG_REMOTE_PORT, rp);
      write_reg(CFG_ACK_TIMEOUT, to);
      write_reg(CFG_MAX_RETRIES, mr);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 79;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct     = 29;
        end
      endcase
      // Fill the block while the receiver holds off.
      if (phase == 0) hold_asks++;
      done = 0;
      while (done < PHASE_ITEMS) begin
        ev = gen_event(noise);
        offer_event(ev, NOT_TYPED, '0);
        if (!noise) done++;
      end
    end

    wait_idle();
    if (error_count == 0)
      $display("tcp_client_connection_engine_top test passed");
    else
      $display("tcp_client_connection_engine_top test failed");
    $finish;
  end

endmodule
